/* src/swf_pkg.sv */
// Package for the silent write filter: field widths, transfer structs,
// the classified job passed from front to back, and configuration codes.
// No dependencies.
package swf_pkg;

    localparam int unsigned CODE_W         = 4;
    localparam int unsigned OPND_W         = 32;
    localparam int unsigned LOC_DEPTH_DEF  = 4096;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned CFG_IDX_W      = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_CODE = 2'd2;

    // Reset values of the code registers
    localparam logic [CODE_W-1:0] READ_CODE_RST  = 4'd0;
    localparam logic [CODE_W-1:0] WRITE_CODE_RST = 4'd1;
    localparam logic [CODE_W-1:0] VALUE_CODE_RST = 4'd2;

    typedef struct packed {
        logic [CODE_W-1:0] cmd_code;
        logic [OPND_W-1:0] operand;
        logic              event_end;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] out_code;
        logic [OPND_W-1:0] out_operand;
        logic              is_command;
        logic              out_event_end;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] read_code;
        logic [CODE_W-1:0] write_code;
        logic [CODE_W-1:0] value_code;
    } codes_t;

    // One classified input: up to two commands, a pair flag asking for
    // the table check, and the event end.
    typedef struct packed {
        logic              a_valid;
        logic [CODE_W-1:0] a_code;
        logic [OPND_W-1:0] a_operand;
        logic              b_valid;
        logic [CODE_W-1:0] b_code;
        logic [OPND_W-1:0] b_operand;
        logic              pair;
        logic              end_flag;
    } job_t;

endpackage

/* src/swf_front.sv */
// Front end of the silent write filter: accepts trace commands, holds a
// pending access, and classifies each transfer into a job for the queue.
// Depends on swf_pkg.
module swf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  swf_pkg::codes_t   codes,
    input  logic              item_valid,
    output logic              item_ready,
    input  swf_pkg::in_item_t item,
    input  logic              busy,
    input  logic              q_full,
    output logic              q_push,
    output swf_pkg::job_t     q_job
);

    logic                       pend_valid_reg;
    logic                       pend_valid_next;
    logic [swf_pkg::CODE_W-1:0] pend_code_reg;
    logic [swf_pkg::CODE_W-1:0] pend_code_next;
    logic [swf_pkg::OPND_W-1:0] pend_loc_reg;
    logic [swf_pkg::OPND_W-1:0] pend_loc_next;
    logic                       accept;
    logic                       is_value;
    logic                       is_access;
    logic                       hold_cur;
    swf_pkg::job_t              job;

    assign item_ready = !busy && !q_full;
    assign accept     = item_valid && item_ready;
    assign is_value   = item.cmd_code == codes.value_code;
    assign is_access  = (item.cmd_code == codes.read_code) ||
                        (item.cmd_code == codes.write_code);
    // an access not at event end waits one transfer for its value
    assign hold_cur   = is_access && !item.event_end;

    // Classification
    always_comb
    begin
        job             = '0;
        job.end_flag    = item.event_end;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        pend_loc_next   = pend_loc_reg;
        if (accept)
        begin
            pend_valid_next = 1'b0;
            if (pend_valid_reg)
            begin
                job.a_valid   = 1'b1;
                job.a_code    = pend_code_reg;
                job.a_operand = pend_loc_reg;
            end
            if (pend_valid_reg && is_value)
            begin
                job.pair      = 1'b1;
                job.b_valid   = 1'b1;
                job.b_code    = item.cmd_code;
                job.b_operand = item.operand;
            end
            else if (hold_cur)
            begin
                pend_valid_next = 1'b1;
                pend_code_next  = item.cmd_code;
                pend_loc_next   = item.operand;
            end
            else
            begin
                job.b_valid   = 1'b1;
                job.b_code    = item.cmd_code;
                job.b_operand = item.operand;
            end
        end
    end

    // jobs with nothing to emit and no event end are not queued
    assign q_push = accept && (job.a_valid || job.b_valid || job.end_flag);
    assign q_job  = job;

    // Pending access
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_code_reg <= pend_code_next;
        pend_loc_reg  <= pend_loc_next;
    end

endmodule

/* src/swf_queue.sv */
// Short job queue between the front and back of the silent write filter.
// Depends on swf_pkg.
module swf_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  swf_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output swf_pkg::job_t head_job
);

    localparam int unsigned CNT_W = $clog2(swf_pkg::QUEUE_DEPTH + 1);

    swf_pkg::job_t                entries_reg [swf_pkg::QUEUE_DEPTH];
    logic [swf_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [swf_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;

    assign full       = count_reg == CNT_W'(swf_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/swf_back.sv */
// Back end of the silent write filter: per-location value table with
// clearing pass and write forwarding, drop decision, two-slot output buffer.
// Depends on swf_pkg.
module swf_back
#(
    parameter int unsigned LOC_DEPTH  = swf_pkg::LOC_DEPTH_DEF,
    parameter int unsigned VALUE_BITS = swf_pkg::VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  swf_pkg::codes_t    codes,
    input  logic               q_valid,
    input  swf_pkg::job_t      q_job,
    output logic               q_pop,
    output logic               busy,
    output logic               result_valid,
    input  logic               result_ready,
    output swf_pkg::out_item_t result
);

    localparam int unsigned IDX_W = $clog2(LOC_DEPTH);

    // table word: known bit over value
    logic [VALUE_BITS:0]       loc_mem [LOC_DEPTH];

    logic                      busy_reg;
    logic [IDX_W-1:0]          clr_cnt_reg;
    logic                      r_valid_reg;
    logic                      r_valid_next;
    swf_pkg::job_t             r_job_reg;
    logic                      r_tracked_reg;
    logic [IDX_W-1:0]          r_idx_reg;
    logic [VALUE_BITS:0]       rd_data_reg;
    logic                      fwd_valid_reg;
    logic [IDX_W-1:0]          fwd_idx_reg;
    logic [VALUE_BITS-1:0]     fwd_value_reg;
    logic                      emitted_reg;
    logic                      emitted_next;
    swf_pkg::out_item_t        slot0_reg;
    swf_pkg::out_item_t        slot0_next;
    swf_pkg::out_item_t        slot1_reg;
    swf_pkg::out_item_t        slot1_next;
    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;

    logic [IDX_W-1:0]          rd_idx;
    logic                      head_tracked;
    logic                      cur_known;
    logic [VALUE_BITS-1:0]     cur_value;
    logic [VALUE_BITS-1:0]     new_value;
    logic                      drop;
    logic [1:0]                n_res;
    logic [1:0]                need;
    logic [1:0]                cnt_after;
    logic [1:0]                space;
    logic                      s_fire;
    logic                      out_pop;
    swf_pkg::out_item_t        res0;
    swf_pkg::out_item_t        res1;
    logic                      mem_we;
    logic [IDX_W-1:0]          mem_waddr;
    logic [VALUE_BITS:0]       mem_wdata;

    assign busy         = busy_reg;
    assign rd_idx       = q_job.a_operand[IDX_W-1:0];
    assign head_tracked = q_job.a_operand < swf_pkg::OPND_W'(LOC_DEPTH);

    // Lookup stage handoff
    assign q_pop        = q_valid && !busy_reg && (!r_valid_reg || s_fire);
    assign r_valid_next = q_pop ? 1'b1 : (s_fire ? 1'b0 : r_valid_reg);

    // Table entry with forwarding of the last write
    always_comb
    begin
        if (fwd_valid_reg && (fwd_idx_reg == r_idx_reg))
        begin
            cur_known = 1'b1;
            cur_value = fwd_value_reg;
        end
        else
        begin
            cur_known = rd_data_reg[VALUE_BITS];
            cur_value = rd_data_reg[VALUE_BITS-1:0];
        end
    end

    assign new_value = VALUE_BITS'(r_job_reg.b_operand);
    assign drop      = r_job_reg.pair && r_tracked_reg &&
                       (r_job_reg.a_code == codes.write_code) &&
                       cur_known && (cur_value == new_value);

    // Result assembly
    always_comb
    begin
        res0  = '0;
        res1  = '0;
        n_res = 2'd0;
        res1.out_code    = r_job_reg.b_code;
        res1.out_operand = r_job_reg.b_operand;
        res1.is_command  = 1'b1;
        if (r_job_reg.pair)
        begin
            res0.out_code    = r_job_reg.a_code;
            res0.out_operand = r_job_reg.a_operand;
            res0.is_command  = 1'b1;
            n_res            = drop ? 2'd0 : 2'd2;
        end
        else if (r_job_reg.a_valid)
        begin
            res0.out_code    = r_job_reg.a_code;
            res0.out_operand = r_job_reg.a_operand;
            res0.is_command  = 1'b1;
            n_res            = r_job_reg.b_valid ? 2'd2 : 2'd1;
        end
        else if (r_job_reg.b_valid)
        begin
            res0  = res1;
            n_res = 2'd1;
        end
        // event ending with nothing emitted: marker only
        if (r_job_reg.end_flag && (n_res == 2'd0) && !emitted_reg)
        begin
            res0  = '0;
            n_res = 2'd1;
        end
        if (n_res == 2'd1)
        begin
            res0.last_of_run   = 1'b1;
            res0.out_event_end = r_job_reg.end_flag;
        end
        else
        begin
            res1.last_of_run   = 1'b1;
            res1.out_event_end = r_job_reg.end_flag;
        end
    end

    // pair jobs reserve two slots before the compare is known
    assign need      = r_job_reg.pair ? 2'd2 : n_res;
    assign out_pop   = result_valid && result_ready;
    assign cnt_after = cnt_reg - {1'b0, out_pop};
    assign space     = 2'd2 - cnt_after;
    assign s_fire    = r_valid_reg && (need <= space);

    always_comb
    begin
        emitted_next = emitted_reg;
        if (s_fire)
        begin
            if (r_job_reg.end_flag)
            begin
                emitted_next = 1'b0;
            end
            else if (n_res != 2'd0)
            begin
                emitted_next = 1'b1;
            end
        end
    end

    // Output buffer: shift out, then append
    always_comb
    begin
        slot0_next = out_pop ? slot1_reg : slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_after;
        if (s_fire)
        begin
            cnt_next = cnt_after + n_res;
            if (cnt_after == 2'd0)
            begin
                slot0_next = res0;
                slot1_next = res1;
            end
            else
            begin
                slot1_next = res0;
            end
        end
    end

    assign result_valid = cnt_reg != 2'd0;
    assign result       = slot0_reg;

    // Table write port: clearing pass or pair update
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = r_idx_reg;
        mem_wdata = {1'b1, new_value};
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else if (s_fire && r_job_reg.pair && r_tracked_reg)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            loc_mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_data_reg <= loc_mem[rd_idx];
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            r_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            emitted_reg   <= 1'b0;
            cnt_reg       <= 2'd0;
        end
        else
        begin
            if (busy_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(LOC_DEPTH - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (s_fire && r_job_reg.pair && r_tracked_reg)
            begin
                fwd_valid_reg <= 1'b1;
            end
            r_valid_reg <= r_valid_next;
            emitted_reg <= emitted_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            r_job_reg     <= q_job;
            r_tracked_reg <= head_tracked;
            r_idx_reg     <= rd_idx;
        end
        if (s_fire && r_job_reg.pair && r_tracked_reg)
        begin
            fwd_idx_reg   <= r_idx_reg;
            fwd_value_reg <= new_value;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

/* src/silent_write_filter.sv */
// Path: an input's results pass through the job queue, the lookup registers and the output buffer;
// an access waits for the next input to learn whether a value follows.
// Throughput: one input per cycle while the queue has room and no clear runs; a two-result
// input holds the single output port for both. The location table is one-read one-write.
// Reset: asynchronous; afterwards item_ready stays low while the table is cleared
// one entry per cycle. Config writes are taken throughout.
module silent_write_filter
#(
    parameter int unsigned LOC_DEPTH  = swf_pkg::LOC_DEPTH_DEF,
    parameter int unsigned VALUE_BITS = swf_pkg::VALUE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  swf_pkg::in_item_t             item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output swf_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [swf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swf_pkg::CODE_W-1:0]    cfg_data
);

    swf_pkg::codes_t codes_reg;
    logic            busy;
    logic            q_full;
    logic            q_push;
    swf_pkg::job_t   q_in_job;
    logic            q_pop;
    logic            q_valid;
    swf_pkg::job_t   q_head_job;

    assign cfg_ready = 1'b1;

    // Code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.read_code  <= swf_pkg::READ_CODE_RST;
            codes_reg.write_code <= swf_pkg::WRITE_CODE_RST;
            codes_reg.value_code <= swf_pkg::VALUE_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                swf_pkg::CFG_READ_CODE:  codes_reg.read_code  <= cfg_data;
                swf_pkg::CFG_WRITE_CODE: codes_reg.write_code <= cfg_data;
                swf_pkg::CFG_VALUE_CODE: codes_reg.value_code <= cfg_data;
                default:                 ;
            endcase
        end
    end

    swf_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .codes      (codes_reg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .busy       (busy),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (q_in_job)
    );

    swf_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    swf_back
    #(
        .LOC_DEPTH  (LOC_DEPTH),
        .VALUE_BITS (VALUE_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .codes        (codes_reg),
        .q_valid      (q_valid),
        .q_job        (q_head_job),
        .q_pop        (q_pop),
        .busy         (busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

/* src/swf_checker.sv */
// Port-level checks for the silent write filter, bound to the top level.
// Depends on swf_pkg and silent_write_filter.
module swf_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input swf_pkg::out_item_t            result
);

    // a stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // a marker carries nothing and closes its event and run
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.is_command |->
            result.out_code == '0 && result.out_operand == '0 &&
            result.out_event_end && result.last_of_run)
        else $error("malformed event marker");

    // the end of an event is also the end of its run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.out_event_end |-> result.last_of_run)
        else $error("event end without last_of_run");

    // no item transfer right after reset: the table is being cleared
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !item_ready && !result_valid)
        else $error("item taken during table clear");

endmodule

bind silent_write_filter swf_checker u_swf_checker (.*);
